// File: sv/dcts_pkg.sv
// ----------------------------------------------------------------------------
// dcts_pkg
// types, constants and helper functions of the digital clock with time set
// ----------------------------------------------------------------------------
package dcts_pkg;

  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_LETTERS = 2'd1,
    MODE_CLOCK   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_TICKS_CS     = 2'd0,
    CFG_TICKS_SAMPLE = 2'd1,
    CFG_BLINK        = 2'd2,
    CFG_ZONE         = 2'd3
  } cfg_idx_e;

  localparam logic [9:0] TICKS_CS_RST     = 10'd10;
  localparam logic [9:0] TICKS_SAMPLE_RST = 10'd50;
  localparam logic [9:0] BLINK_RST        = 10'd200;
  localparam logic [4:0] ZONE_RST         = 5'd8;

  localparam logic [6:0] CS_MOD  = 7'd100;
  localparam logic [6:0] SEC_MOD = 7'd60;
  localparam logic [6:0] HR_MOD  = 7'd24;

  // key bit positions
  localparam int KEY_LEFT  = 0;
  localparam int KEY_DOWN  = 1;
  localparam int KEY_RIGHT = 2;
  localparam int KEY_SET   = 5;
  localparam int KEY_UP    = 6;
  localparam int KEY_RUN   = 7;
  localparam int BTN_PREV  = 0;
  localparam int BTN_NEXT  = 1;

  localparam logic [2:0] SEL_LAST = 3'd5;

  localparam logic [7:0] FIXED_SEG [8] = '{
    8'h06, 8'h6F, 8'h5B, 8'h7D, 8'h3F, 8'h7F, 8'h06, 8'h07
  };
  localparam logic [7:0] LETTER_SEG [8] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76
  };

  typedef struct packed {
    logic       car;
    logic [6:0] val;
  } fld_step_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // tens digit of a value below 100, by reciprocal multiply
  function automatic logic [3:0] dec_tens(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] dec_ones(input logic [6:0] v);
    logic [6:0] t;
    t = {3'd0, dec_tens(v)} * 7'd10;
    return 4'(v - t);
  endfunction

  // add or subtract a small amount within a modulus, with carry or borrow
  function automatic fld_step_t step_field(input logic [6:0] v, input logic [3:0] a,
                                           input logic [6:0] m, input logic dn);
    fld_step_t  r;
    logic [7:0] t;
    if (dn) begin
      t     = {1'b0, v} - {4'd0, a};
      r.car = t[7];
      r.val = t[7] ? 7'(t + {1'b0, m}) : t[6:0];
    end else begin
      t     = {1'b0, v} + {4'd0, a};
      r.car = (t >= {1'b0, m});
      r.val = r.car ? 7'(t - {1'b0, m}) : t[6:0];
    end
    return r;
  endfunction

endpackage

// File: sv/digital_clock_with_time_set.sv
// ----------------------------------------------------------------------------
// digital_clock_with_time_set
// eight-position seven-segment clock with key-driven time set and mode select
// ----------------------------------------------------------------------------
// Each input transfer is one tick carrying the active-low key and button
// levels; each tick yields exactly one output transfer with eight segment
// words, the display mode and the set flag.
// Input: s_axis group, tdata = keys [7:0], buttons [9:8].
// Output: m_axis group, tdata = seg words 0..7 [63:0], mode [65:64],
// set flag [66].
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i at a rising
// edge; write only while no tick is in flight.
// Throughput: one tick per cycle while m_axis is not stalled; the whole tick
// (prescalers, key sampling, time count, time step, digit decode) is done
// combinationally between the input register and the output register.
// Reset: time 00:00:00.00 (shown with the zone offset), clock mode, not
// setting, registers at 10 / 50 / 200 / 8.
// Stall: while m_axis_tready_i is low the output register holds, the input
// register fills once more and then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module digital_clock_with_time_set
  import dcts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // keypad_levels, button_levels, zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // seg_word_0..7, shown_mode, setting_time, zero fill
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  logic [9:0] tpc_q, tps_q, bp_q;
  logic [4:0] zone_q;

  logic        in_vld_q, out_vld_q, out_free, adv;
  logic [9:0]  in_data_q;
  logic [71:0] out_data_q, out_data_d;

  logic [9:0] cs_pre_q, cs_pre_d, cs_pre_inc;
  logic [9:0] smp_pre_q, smp_pre_d, smp_pre_inc;
  logic [9:0] blink_q, blink_d, blink_inc;
  logic       cs_fire, smp_fire, blank;

  logic [7:0] last_keys_q, last_keys_d, keys_now, keys_rise;
  logic [1:0] last_btn_q, last_btn_d, btn_now, btn_rise;

  mode_e      mode_q, mode_d, mode_b;
  logic       set_q, set_d, setting;
  logic [2:0] sel_q, sel_d;

  logic [4:0] hr_q, hr_d, c_hr;
  logic [5:0] mn_q, mn_d, c_mn;
  logic [5:0] sc_q, sc_d, c_sc;
  logic [6:0] cc_q, cc_d, c_cc;
  logic       count_en, inc_sc, inc_mn, inc_hr;

  logic       step_up, step_dn, step_any;
  logic [3:0] amt, amt_sc, amt_mn, amt_hr;
  fld_step_t  st_sc, st_mn, st_hr;

  logic [5:0] hz_sum;
  logic [6:0] hz;
  logic [7:0] seg_w [8];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q  <= TICKS_CS_RST;
      tps_q  <= TICKS_SAMPLE_RST;
      bp_q   <= BLINK_RST;
      zone_q <= ZONE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TICKS_CS:     tpc_q  <= cfg_data_i;
        CFG_TICKS_SAMPLE: tps_q  <= cfg_data_i;
        CFG_BLINK:        bp_q   <= cfg_data_i;
        CFG_ZONE:         zone_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign adv             = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // prescalers and blink phase
  always_comb begin
    cs_pre_inc  = cs_pre_q + 10'd1;
    cs_fire     = (cs_pre_inc >= tpc_q) || (cs_pre_inc == '0);
    cs_pre_d    = cs_fire ? '0 : cs_pre_inc;
    smp_pre_inc = smp_pre_q + 10'd1;
    smp_fire    = (smp_pre_inc >= tps_q) || (smp_pre_inc == '0);
    smp_pre_d   = smp_fire ? '0 : smp_pre_inc;
    blink_inc   = blink_q + 10'd1;
    blink_d     = (blink_inc >= bp_q) ? '0 : blink_inc;
    blank       = blink_d < {1'b0, bp_q[9:1]};
  end

  // key sampling and press detection
  always_comb begin
    keys_now    = ~in_data_q[7:0];
    btn_now     = ~in_data_q[9:8];
    keys_rise   = smp_fire ? (keys_now & ~last_keys_q) : '0;
    btn_rise    = smp_fire ? (btn_now & ~last_btn_q) : '0;
    last_keys_d = smp_fire ? keys_now : last_keys_q;
    last_btn_d  = smp_fire ? btn_now : last_btn_q;
  end

  // time count
  always_comb begin
    count_en = !set_q && cs_fire;
    inc_sc   = count_en && (cc_q == CS_MOD - 7'd1);
    inc_mn   = inc_sc && (sc_q == 6'(SEC_MOD - 7'd1));
    inc_hr   = inc_mn && (mn_q == 6'(SEC_MOD - 7'd1));
    c_cc     = count_en ? ((cc_q == CS_MOD - 7'd1) ? '0 : cc_q + 7'd1) : cc_q;
    c_sc     = inc_sc ? ((sc_q == 6'(SEC_MOD - 7'd1)) ? '0 : sc_q + 6'd1) : sc_q;
    c_mn     = inc_mn ? ((mn_q == 6'(SEC_MOD - 7'd1)) ? '0 : mn_q + 6'd1) : mn_q;
    c_hr     = inc_hr ? ((hr_q == 5'(HR_MOD - 7'd1)) ? '0 : hr_q + 5'd1) : hr_q;
  end

  // mode, set flag and digit selection
  always_comb begin
    mode_b = mode_q;
    if (btn_rise[BTN_PREV]) begin
      unique case (mode_q)
        MODE_FIXED:   mode_b = MODE_CLOCK;
        MODE_LETTERS: mode_b = MODE_FIXED;
        default:      mode_b = MODE_LETTERS;
      endcase
    end
    mode_d = mode_b;
    if (btn_rise[BTN_NEXT]) begin
      unique case (mode_b)
        MODE_FIXED:   mode_d = MODE_LETTERS;
        MODE_LETTERS: mode_d = MODE_CLOCK;
        default:      mode_d = MODE_FIXED;
      endcase
    end

    set_d = set_q;
    if (mode_d == MODE_CLOCK) begin
      if (keys_rise[KEY_SET]) begin
        set_d = 1'b1;
      end else if (keys_rise[KEY_RUN]) begin
        set_d = 1'b0;
      end
    end
    setting = (mode_d == MODE_CLOCK) && set_d;

    sel_d = sel_q;
    if (setting && keys_rise[KEY_LEFT] && !keys_rise[KEY_RIGHT]) begin
      sel_d = (sel_q == '0) ? SEL_LAST : sel_q - 3'd1;
    end else if (setting && keys_rise[KEY_RIGHT] && !keys_rise[KEY_LEFT]) begin
      sel_d = (sel_q == SEL_LAST) ? '0 : sel_q + 3'd1;
    end
  end

  // time step: hour, minute or second level, by ten or by one
  always_comb begin
    step_up  = setting && keys_rise[KEY_UP] && !keys_rise[KEY_DOWN];
    step_dn  = setting && keys_rise[KEY_DOWN] && !keys_rise[KEY_UP];
    step_any = step_up || step_dn;
    amt      = sel_d[0] ? 4'd1 : 4'd10;
    amt_sc   = (sel_d[2:1] == 2'd2) ? amt : '0;
    st_sc    = step_field({1'b0, c_sc}, amt_sc, SEC_MOD, step_dn);
    amt_mn   = (sel_d[2:1] == 2'd1) ? amt : {3'd0, st_sc.car};
    st_mn    = step_field({1'b0, c_mn}, amt_mn, SEC_MOD, step_dn);
    amt_hr   = (sel_d[2:1] == 2'd0) ? amt : {3'd0, st_mn.car};
    st_hr    = step_field({2'b0, c_hr}, amt_hr, HR_MOD, step_dn);
    cc_d     = c_cc;
    sc_d     = step_any ? st_sc.val[5:0] : c_sc;
    mn_d     = step_any ? st_mn.val[5:0] : c_mn;
    hr_d     = step_any ? st_hr.val[4:0] : c_hr;
  end

  // display words
  always_comb begin
    hz_sum = {1'b0, c_hr} + {1'b0, zone_q};
    if (hz_sum >= 6'(2 * HR_MOD)) begin
      hz = 7'(hz_sum - 6'(2 * HR_MOD));
    end else if (hz_sum >= 6'(HR_MOD)) begin
      hz = 7'(hz_sum - 6'(HR_MOD));
    end else begin
      hz = {1'b0, hz_sum};
    end
    for (int i = 0; i < 8; i++) begin
      seg_w[i] = '0;
    end
    unique case (mode_d)
      MODE_FIXED: begin
        for (int i = 0; i < 8; i++) begin
          seg_w[i] = FIXED_SEG[i];
        end
      end
      MODE_LETTERS: begin
        for (int i = 0; i < 8; i++) begin
          seg_w[i] = LETTER_SEG[i];
        end
      end
      default: begin
        seg_w[0] = seg_digit(dec_tens(hz));
        seg_w[1] = seg_digit(dec_ones(hz));
        seg_w[2] = seg_digit(dec_tens({1'b0, c_mn}));
        seg_w[3] = seg_digit(dec_ones({1'b0, c_mn}));
        seg_w[4] = seg_digit(dec_tens({1'b0, c_sc}));
        seg_w[5] = seg_digit(dec_ones({1'b0, c_sc}));
        seg_w[6] = seg_digit(dec_tens(c_cc));
        seg_w[7] = seg_digit(dec_ones(c_cc));
        for (int i = 0; i < 6; i++) begin
          if (set_d && blank && (sel_d == 3'(i))) begin
            seg_w[i] = '0;
          end
        end
      end
    endcase
    out_data_d = {5'd0, set_d, mode_d, seg_w[7], seg_w[6], seg_w[5], seg_w[4],
                  seg_w[3], seg_w[2], seg_w[1], seg_w[0]};
  end

  // handshake stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i[9:0];
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  // clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_pre_q    <= '0;
      smp_pre_q   <= '0;
      blink_q     <= '0;
      last_keys_q <= '0;
      last_btn_q  <= '0;
      mode_q      <= MODE_CLOCK;
      set_q       <= 1'b0;
      sel_q       <= '0;
      hr_q        <= '0;
      mn_q        <= '0;
      sc_q        <= '0;
      cc_q        <= '0;
    end else if (adv) begin
      cs_pre_q    <= cs_pre_d;
      smp_pre_q   <= smp_pre_d;
      blink_q     <= blink_d;
      last_keys_q <= last_keys_d;
      last_btn_q  <= last_btn_d;
      mode_q      <= mode_d;
      set_q       <= set_d;
      sel_q       <= sel_d;
      hr_q        <= hr_d;
      mn_q        <= mn_d;
      sc_q        <= sc_d;
      cc_q        <= cc_d;
    end
  end

`ifndef SYNTH
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= SEL_LAST)
    else $error("selected digit out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hr_q < 5'(HR_MOD)) && (mn_q < 6'(SEC_MOD)) && (sc_q < 6'(SEC_MOD)) && (cc_q < CS_MOD))
    else $error("time field out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> ($stable(cc_q) && $stable(set_q) && $stable(mode_q)))
    else $error("state changed while stalled");

  a_no_count_when_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && set_q && !keys_rise[KEY_UP] && !keys_rise[KEY_DOWN]) |=> $stable(cc_q))
    else $error("clock counted while in set mode");
`endif

endmodule
